/* rtl/point_cloud_bev_occupancy_macros.svh */
// assertion macros for the bev occupancy block
`ifndef POINT_CLOUD_BEV_OCCUPANCY_MACROS_SVH
`define POINT_CLOUD_BEV_OCCUPANCY_MACROS_SVH

// implication checked on every clock, masked in reset
`define BEV_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// non-overlapped implication
`define BEV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/bev_pkg.sv */
// shared types and constants for the bev occupancy block
package bev_pkg;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_BUILD = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_CLIPPED = 2'd2;
   localparam logic [1:0] ST_DROPPED = 2'd3;

   localparam logic [1:0] CSR_SCALE = 2'd0;
   localparam logic [1:0] CSR_MINH  = 2'd1;
   localparam logic [1:0] CSR_MAXH  = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_SIZE_Y,
      S_SIZE_X,
      S_FETCH,
      S_WAIT,
      S_PROJ_X,
      S_PROJ_Y,
      S_CHECK,
      S_RMW,
      S_READ,
      S_READ_OUT,
      S_DONE
   } state_type;

   // one shared multiply: signed operand times unsigned scale
   typedef struct packed {
      logic signed [17:0] operand;
      logic [15:0]        scale;
   } mul_req_type;

endpackage

/* rtl/point_cloud_bev_occupancy.sv */
// top level: point store, bitmap memory and build sequencer around one multiplier
// a load leaves busy low; a read is busy in S_READ and S_READ_OUT and strobes in S_READ_OUT
// a build clears the bitmap, sizes the grid, walks each stored point through S_FETCH to S_RMW
// and sets the status in S_DONE, then strobes as busy falls
// the receiver cannot stall the result strobe
// reset (synchronous, active high) empties the store and returns an empty image, status 1
module point_cloud_bev_occupancy #(
   parameter int MAX_POINTS = 4096,
   parameter int MAX_ROWS   = 256,
   parameter int MAX_COLS   = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_operation,
   input  logic signed [15:0]  req_pos_x,
   input  logic signed [15:0]  req_pos_y,
   input  logic signed [15:0]  req_pos_z,
   input  logic [7:0]          req_read_row,
   input  logic [1:0]          req_read_word,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_data,
   output logic                rsp_strobe,
   output logic [63:0]         rsp_bitmap_word,
   output logic [8:0]          rsp_grid_rows,
   output logic [8:0]          rsp_grid_cols,
   output logic [12:0]         rsp_points_drawn,
   output logic [1:0]          rsp_status
);
`include "point_cloud_bev_occupancy_macros.svh"

   localparam int ROW_WORDS = (MAX_COLS + 63) / 64;
   localparam int PAW = $clog2(MAX_POINTS);
   localparam int CW  = $clog2(MAX_POINTS + 1);
   localparam int RW  = $clog2(MAX_ROWS);
   localparam int WW  = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
   localparam int BW  = RW + WW;
   localparam int BDEPTH = MAX_ROWS * ROW_WORDS;
   localparam int SZW = $clog2(MAX_COLS + 1) > $clog2(MAX_ROWS + 1) ?
                        $clog2(MAX_COLS + 1) : $clog2(MAX_ROWS + 1);

   // memories
   logic [47:0] store_mem [MAX_POINTS];
   logic [63:0] bitmap_mem [BDEPTH];
   logic [47:0] store_q;
   logic [63:0] bitmap_q;

   bev_pkg::state_type state_ff, state_in;

   logic [15:0]        scale_ff;
   logic signed [15:0] minh_ff, maxh_ff;
   logic [CW-1:0]      count_ff;
   logic signed [15:0] xlo_ff, xhi_ff, ylo_ff, yhi_ff;
   logic [SZW-1:0]     rows_ff, rows_in, cols_ff, cols_in;
   logic               dropped_ff;
   logic [12:0]        drawn_ff, drawn_in;
   logic [1:0]         status_ff, status_in;
   logic               clip_ff, clip_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [BW-1:0]      baddr_ff, baddr_in;
   logic signed [35:0] colv_ff, colv_in;
   logic signed [35:0] rowv_ff, rowv_in;
   logic [7:0]         rrow_ff;
   logic [1:0]         rword_ff;
   logic               rvalid_ff;
   // bitmap holds valid data only once a build has swept it clear
   logic               built_ff;

   // shared multiplier
   bev_pkg::mul_req_type mreq;
   logic signed [34:0]   mprod;
   bev_mul u_mul (.clock(clock), .req(mreq), .product(mprod));

   logic accept;
   assign accept = start && !busy;
   assign busy = (state_ff != bev_pkg::S_IDLE);
   assign csr_ready = 1'b1;

   // fields of fetched point
   logic signed [15:0] sx, sy, sz;
   assign sx = store_q[15:0];
   assign sy = store_q[31:16];
   assign sz = store_q[47:32];

   // operand mux for the multiplier
   logic signed [17:0] span_y, span_x, dx, dy;
   assign span_y = 18'(yhi_ff) - 18'(ylo_ff);
   assign span_x = 18'(xhi_ff) - 18'(xlo_ff);
   assign dx = 18'(sx) * 18'sd2 - (18'(xlo_ff) + 18'(xhi_ff));
   assign dy = 18'(sy) * 18'sd2 - (18'(ylo_ff) + 18'(yhi_ff));

   logic signed [17:0] dx_ff, dy_ff;
   logic signed [17:0] mag_sel;
   always_comb begin
      unique case (state_ff)
         bev_pkg::S_CLEAR:  mag_sel = span_y;
         bev_pkg::S_SIZE_Y: mag_sel = span_x;
         bev_pkg::S_PROJ_X: mag_sel = dy_ff[17] ? -dy_ff : dy_ff;
         default:           mag_sel = dx[17] ? -dx : dx;
      endcase
   end
   assign mreq.operand = mag_sel;
   assign mreq.scale   = scale_ff;

   // size computation from product (span nonnegative here)
   logic [18:0] size_raw;
   assign size_raw = mprod[34:16];

   // projected coordinate: trunc toward zero then add half size
   logic signed [35:0] proj_mag;
   assign proj_mag = 36'(mprod >>> 17);

   // bitmap word address and bit of current point
   logic [RW-1:0] prow;
   logic [SZW-1:0] pcol;
   assign prow = rowv_ff[RW-1:0];
   assign pcol = colv_ff[SZW-1:0];
   logic [BW-1:0] paddr;
   logic [WW-1:0] pword;
   assign pword = WW'(pcol >> 6);
   assign paddr = BW'(BW'(prow) * BW'(ROW_WORDS) + BW'(pword));

   logic in_img;
   assign in_img = !colv_ff[35] && (colv_ff < 36'(cols_ff)) &&
                   !rowv_ff[35] && (rowv_ff < 36'(rows_ff)) &&
                   (sz >= minh_ff) && (sz <= maxh_ff);
   logic hit_ff;

   // memory ports
   logic          st_we;
   logic          bm_we;
   logic [BW-1:0] bm_waddr;
   logic [63:0]   bm_wdata;
   logic [BW-1:0] bm_raddr;
   logic [PAW-1:0] st_raddr;

   always_ff @(posedge clock) begin
      if (st_we) begin
         store_mem[count_ff[PAW-1:0]] <= {req_pos_z, req_pos_y, req_pos_x};
      end
      store_q <= store_mem[st_raddr];
      if (bm_we) begin
         bitmap_mem[bm_waddr] <= bm_wdata;
      end
      bitmap_q <= bitmap_mem[bm_raddr];
   end

   assign st_raddr = idx_ff[PAW-1:0];
   assign st_we = accept && (req_operation == bev_pkg::OP_LOAD) &&
                  (count_ff < CW'(MAX_POINTS));

   // read address valid for the requested row and word
   logic rd_ok;
   assign rd_ok = (32'(rrow_ff) < MAX_ROWS) && (32'(rword_ff) < ROW_WORDS);

   always_comb begin
      state_in  = state_ff;
      rows_in   = rows_ff;
      cols_in   = cols_ff;
      drawn_in  = drawn_ff;
      status_in = status_ff;
      clip_in   = clip_ff;
      idx_in    = idx_ff;
      baddr_in  = baddr_ff;
      colv_in   = colv_ff;
      rowv_in   = rowv_ff;
      bm_we     = 1'b0;
      bm_waddr  = baddr_ff;
      bm_wdata  = '0;
      bm_raddr  = paddr;
      unique case (state_ff)
         bev_pkg::S_IDLE: begin
            if (accept) begin
               unique case (req_operation)
                  bev_pkg::OP_BUILD: begin
                     state_in = bev_pkg::S_CLEAR;
                     baddr_in = '0;
                     clip_in  = 1'b0;
                     drawn_in = '0;
                     idx_in   = '0;
                  end
                  bev_pkg::OP_READ: state_in = bev_pkg::S_READ;
                  default: state_in = bev_pkg::S_IDLE;
               endcase
            end
         end
         bev_pkg::S_CLEAR: begin
            // sweep zeros through the bitmap; multiplier sees span_y meanwhile
            bm_we    = 1'b1;
            bm_waddr = baddr_ff;
            baddr_in = baddr_ff + 1'b1;
            if (32'(baddr_ff) == BDEPTH - 1) begin
               state_in = bev_pkg::S_SIZE_Y;
            end
         end
         bev_pkg::S_SIZE_Y: begin
            if (count_ff == '0) begin
               rows_in = '0;
            end else if (size_raw > 19'(MAX_ROWS)) begin
               rows_in = SZW'(MAX_ROWS);
               clip_in = 1'b1;
            end else begin
               rows_in = SZW'(size_raw);
            end
            state_in = bev_pkg::S_SIZE_X;
         end
         bev_pkg::S_SIZE_X: begin
            if (count_ff == '0) begin
               cols_in = '0;
            end else if (size_raw > 19'(MAX_COLS)) begin
               cols_in = SZW'(MAX_COLS);
               clip_in = 1'b1;
            end else begin
               cols_in = SZW'(size_raw);
            end
            state_in = (count_ff == '0) ? bev_pkg::S_DONE : bev_pkg::S_FETCH;
         end
         bev_pkg::S_FETCH: state_in = bev_pkg::S_WAIT;
         bev_pkg::S_WAIT: state_in = bev_pkg::S_PROJ_X;
         bev_pkg::S_PROJ_X: begin
            // product of |dx| launched in S_WAIT
            colv_in = (dx_ff[17] ? -proj_mag : proj_mag) + 36'(cols_ff >> 1);
            state_in = bev_pkg::S_PROJ_Y;
         end
         bev_pkg::S_PROJ_Y: begin
            // product of |dy| launched in S_PROJ_X
            rowv_in = (dy_ff[17] ? -proj_mag : proj_mag) + 36'(rows_ff >> 1);
            state_in = bev_pkg::S_CHECK;
         end
         bev_pkg::S_CHECK: state_in = bev_pkg::S_RMW;
         bev_pkg::S_RMW: begin
            // bitmap_q was read at paddr in the previous cycle
            if (hit_ff) begin
               bm_we    = 1'b1;
               bm_waddr = paddr;
               bm_wdata = bitmap_q | (64'd1 << pcol[5:0]);
               drawn_in = drawn_ff + 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            state_in = (idx_ff + 1'b1 == count_ff) ? bev_pkg::S_DONE : bev_pkg::S_FETCH;
         end
         bev_pkg::S_READ: begin
            bm_raddr = BW'(BW'(rrow_ff) * BW'(ROW_WORDS) + BW'(rword_ff));
            state_in = bev_pkg::S_READ_OUT;
         end
         bev_pkg::S_READ_OUT: state_in = bev_pkg::S_IDLE;
         bev_pkg::S_DONE: begin
            if (dropped_ff) status_in = bev_pkg::ST_DROPPED;
            else if (count_ff == '0) status_in = bev_pkg::ST_EMPTY;
            else if (clip_ff) status_in = bev_pkg::ST_CLIPPED;
            else status_in = bev_pkg::ST_OK;
            state_in = bev_pkg::S_IDLE;
         end
         default: state_in = bev_pkg::S_IDLE;
      endcase
   end

   // column and row are both settled in S_CHECK, where the bitmap word is read too,
   // so the hit registered there lines up with bitmap_q in S_RMW
   logic hit_now;
   assign hit_now = in_img;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= bev_pkg::S_IDLE;
         scale_ff   <= 16'd6554;
         minh_ff    <= 16'sd20;
         maxh_ff    <= 16'sd250;
         count_ff   <= '0;
         xlo_ff     <= 16'sh7FFF;
         ylo_ff     <= 16'sh7FFF;
         xhi_ff     <= 16'sh8000;
         yhi_ff     <= 16'sh8000;
         rows_ff    <= '0;
         cols_ff    <= '0;
         dropped_ff <= 1'b0;
         drawn_ff   <= '0;
         status_ff  <= bev_pkg::ST_EMPTY;
         clip_ff    <= 1'b0;
         idx_ff     <= '0;
         baddr_ff   <= '0;
         rvalid_ff  <= 1'b0;
         built_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rows_ff   <= rows_in;
         cols_ff   <= cols_in;
         drawn_ff  <= drawn_in;
         status_ff <= status_in;
         clip_ff   <= clip_in;
         idx_ff    <= idx_in;
         baddr_ff  <= baddr_in;
         rvalid_ff <= (state_ff == bev_pkg::S_READ) ||
                      (state_ff == bev_pkg::S_DONE);
         if (state_ff == bev_pkg::S_SIZE_Y) begin
            built_ff <= 1'b1;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               bev_pkg::CSR_SCALE: scale_ff <= csr_data;
               bev_pkg::CSR_MINH:  minh_ff  <= csr_data;
               bev_pkg::CSR_MAXH:  maxh_ff  <= csr_data;
               default: ;
            endcase
         end
         if (accept && req_operation == bev_pkg::OP_LOAD) begin
            if (count_ff < CW'(MAX_POINTS)) begin
               count_ff <= count_ff + 1'b1;
               if (req_pos_x < xlo_ff) xlo_ff <= req_pos_x;
               if (req_pos_x > xhi_ff) xhi_ff <= req_pos_x;
               if (req_pos_y < ylo_ff) ylo_ff <= req_pos_y;
               if (req_pos_y > yhi_ff) yhi_ff <= req_pos_y;
            end else begin
               dropped_ff <= 1'b1;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      colv_ff <= colv_in;
      rowv_ff <= rowv_in;
      if (accept) begin
         rrow_ff  <= req_read_row;
         rword_ff <= req_read_word;
      end
      if (state_ff == bev_pkg::S_WAIT) begin
         dx_ff <= dx;
         dy_ff <= dy;
      end
      hit_ff <= hit_now;
   end

   // response; an unbuilt bitmap reads as zero
   logic rd_sel_ff;
   always_ff @(posedge clock) begin
      rd_sel_ff <= (state_ff == bev_pkg::S_READ) && rd_ok && built_ff;
   end
   assign rsp_strobe       = rvalid_ff;
   assign rsp_bitmap_word  = rd_sel_ff ? bitmap_q : 64'd0;
   assign rsp_grid_rows    = 9'(rows_ff);
   assign rsp_grid_cols    = 9'(cols_ff);
   assign rsp_points_drawn = drawn_ff;
   assign rsp_status       = status_ff;

   `BEV_ASSERT_NEXT(a_strobe_one, rsp_strobe, !rsp_strobe, "result strobe lasted two cycles")
   `BEV_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CW'(MAX_POINTS), "point count over store")
   `BEV_ASSERT_IMP(a_no_accept_busy, state_ff != bev_pkg::S_IDLE, busy, "busy low while working")
endmodule

/* rtl/bev_mul.sv */
// registered shared multiplier: signed 18 bit by unsigned 16 bit
module bev_mul (
   input  logic                      clock,
   input  bev_pkg::mul_req_type      req,
   output logic signed [34:0]        product
);
   logic signed [34:0] product_ff;
   logic signed [34:0] product_in;

   assign product_in = req.operand * $signed({1'b0, req.scale});

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;
endmodule
